/* rtl/bstk_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bstk_pkg
// Shared constants and helpers for the mixed-width byte stack.
// ----------------------------------------------------------------------------
package bstk_pkg;

    localparam int DEPTH_BYTES_DEF = 1024;
    localparam int LANES           = 8;
    localparam int LANE_W          = 3;
    localparam int FILL_W          = 11;
    localparam int NB_W            = 4;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    // access width in bytes: 1, 2, 4 or 8
    function automatic logic [NB_W-1:0] size_bytes(input logic [1:0] code);
        size_bytes = NB_W'(1) << code;
    endfunction

endpackage

/* rtl/bstk_lane_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bstk_lane_ram
// One byte lane of the stack store: single port, registered read data.
// ----------------------------------------------------------------------------
module bstk_lane_ram #(
    parameter int ROWS  = 128,
    parameter int ROW_W = 7
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [ROW_W-1:0] addr,
    input  logic [7:0]       wdata,
    output logic [7:0]       rdata
);

    logic [7:0] mem [ROWS];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end else begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/mixed_width_byte_stack_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mixed_width_byte_stack_top
// Byte-addressed LIFO taking 1/2/4/8-byte push and pop requests, stored
// across eight byte-lane RAMs with one row per eight bytes.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_func, s_size_code, s_push_value
//  m_        out        m_valid/m_ready    m_pop_value, m_status, m_fill_level
//
//  A push or a refused request has its result registered at the accept edge.
//  A successful pop first registers the read in the lane RAMs, then the
//  reassembled bytes as its result; s_ready is low during that read.
//  Synchronous active-low reset empties the stack; no clearing pass.
//  s_ready also drops while a result waits on a stalled m_ready.
// ----------------------------------------------------------------------------
module mixed_width_byte_stack_top
    import bstk_pkg::*;
#(
    parameter int DEPTH_BYTES = DEPTH_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_func,
    input  logic [1:0]        s_size_code,
    input  logic [63:0]       s_push_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [63:0]       m_pop_value,
    output logic [1:0]        m_status,
    output logic [FILL_W-1:0] m_fill_level
);

    localparam int LVL_W = $clog2(DEPTH_BYTES + 1);
    localparam int ROWS  = (DEPTH_BYTES + LANES - 1) / LANES;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int RB_W  = LVL_W - LANE_W + 1;

    logic [LVL_W-1:0]  level_reg, level_next;
    logic              rd_pending_reg, rd_pending_next;
    logic              m_valid_reg, m_valid_next;
    logic [63:0]       pop_value_reg, pop_value_next;
    logic [1:0]        status_reg, status_next;
    logic [LVL_W-1:0]  fill_reg, fill_next;
    logic [LANE_W-1:0] off_reg, off_next;
    logic [NB_W-1:0]   nb_reg, nb_next;

    logic              accept;
    logic [NB_W-1:0]   nb;
    logic [LVL_W:0]    push_end;
    logic              overflow, underflow;
    logic [LVL_W-1:0]  base;
    logic [LANE_W-1:0] off;
    logic [RB_W-1:0]   row0;
    logic [63:0]       pop_data;
    logic [FILL_W+LVL_W-1:0] fill_ext;

    logic [ROW_W-1:0]  lane_row   [LANES];
    logic              lane_we    [LANES];
    logic [7:0]        lane_wdata [LANES];
    logic [7:0]        lane_rdata [LANES];

    assign s_ready = !rd_pending_reg && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    assign nb        = size_bytes(s_size_code);
    assign push_end  = {1'b0, level_reg} + (LVL_W+1)'(nb);
    assign overflow  = push_end > (LVL_W+1)'(DEPTH_BYTES);
    assign underflow = level_reg < LVL_W'(nb);
    assign base      = (s_func == FUNC_POP) ? level_reg - LVL_W'(nb) : level_reg;
    assign off       = base[LANE_W-1:0];
    assign row0      = RB_W'(base >> LANE_W);

    // lane l holds the byte (l - off) mod 8 of the access; lanes below the
    // start offset fall on the next row
    always_comb begin
        logic [LANE_W-1:0] k;
        logic [RB_W-1:0]   row;
        for (int l = 0; l < LANES; l++) begin
            k   = LANE_W'(l) - off;
            row = row0 + RB_W'(LANE_W'(l) < off);
            lane_row[l]   = (row < RB_W'(ROWS)) ? row[ROW_W-1:0] : '0;
            lane_we[l]    = accept && (s_func == FUNC_PUSH) && !overflow
                            && ({1'b0, k} < nb);
            lane_wdata[l] = s_push_value[8*k +: 8];
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        bstk_lane_ram #(
            .ROWS  (ROWS),
            .ROW_W (ROW_W)
        ) u_ram (
            .aclk  (aclk),
            .we    (lane_we[g]),
            .addr  (lane_row[g]),
            .wdata (lane_wdata[g]),
            .rdata (lane_rdata[g])
        );
    end

    // reassemble popped bytes little-endian, zeroing beyond the width
    always_comb begin
        logic [LANE_W-1:0] src;
        pop_data = '0;
        for (int k = 0; k < LANES; k++) begin
            src = off_reg + LANE_W'(k);
            if (NB_W'(k) < nb_reg) begin
                pop_data[8*k +: 8] = lane_rdata[src];
            end
        end
    end

    always_comb begin
        level_next      = level_reg;
        rd_pending_next = 1'b0;
        m_valid_next    = m_valid_reg && !m_ready;
        pop_value_next  = pop_value_reg;
        status_next     = status_reg;
        fill_next       = fill_reg;
        off_next        = off_reg;
        nb_next         = nb_reg;
        if (rd_pending_reg) begin
            m_valid_next   = 1'b1;
            pop_value_next = pop_data;
        end else if (accept) begin
            pop_value_next = '0;
            off_next       = off;
            nb_next        = nb;
            m_valid_next   = 1'b1;
            if (s_func == FUNC_PUSH) begin
                if (overflow) begin
                    status_next = ST_OVERFLOW;
                end else begin
                    status_next = ST_OK;
                    level_next  = push_end[LVL_W-1:0];
                end
            end else if (underflow) begin
                status_next = ST_UNDERFLOW;
            end else begin
                status_next     = ST_OK;
                level_next      = base;
                rd_pending_next = 1'b1;
                m_valid_next    = 1'b0;
            end
            fill_next = level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg      <= '0;
            rd_pending_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            level_reg      <= level_next;
            rd_pending_reg <= rd_pending_next;
            m_valid_reg    <= m_valid_next;
        end
        pop_value_reg <= pop_value_next;
        status_reg    <= status_next;
        fill_reg      <= fill_next;
        off_reg       <= off_next;
        nb_reg        <= nb_next;
    end

    assign fill_ext     = {{FILL_W{1'b0}}, fill_reg};
    assign m_valid      = m_valid_reg;
    assign m_pop_value  = pop_value_reg;
    assign m_status     = status_reg;
    assign m_fill_level = fill_ext[FILL_W-1:0];

endmodule

/* bench/byte_stack_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stack_checker
// Watches the request and result channels of the byte stack, keeps its own
// copy of the stored bytes and fill level, and compares every result with
// the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module byte_stack_checker
    import bstk_pkg::*;
#(
    parameter int DEPTH_BYTES = DEPTH_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic              s_func,
    input  logic [1:0]        s_size_code,
    input  logic [63:0]       s_push_value,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [63:0]       m_pop_value,
    input  logic [1:0]        m_status,
    input  logic [FILL_W-1:0] m_fill_level,
    output int                fail_count,
    output int                outstanding
);

    typedef struct packed {
        logic [63:0]       value;
        logic [1:0]        status;
        logic [FILL_W-1:0] fill;
    } stack_result_t;

    logic [7:0]    stack_bytes [DEPTH_BYTES];
    int            stack_level = 0;
    int            errors      = 0;
    stack_result_t expected_results [$];

    // applies one request to the local stack copy and returns its result
    function automatic stack_result_t predict_request(input logic func,
                                                      input logic [1:0] size_code,
                                                      input logic [63:0] data);
        stack_result_t res;
        int            nbytes;
        nbytes     = 32'(1) << size_code;
        res.value  = '0;
        res.status = ST_OK;
        if (func == FUNC_PUSH) begin
            if (stack_level + nbytes > DEPTH_BYTES) begin
                res.status = ST_OVERFLOW;
            end else begin
                for (int k = 0; k < nbytes; k++)
                    stack_bytes[stack_level + k] = data[8*k +: 8];
                stack_level += nbytes;
            end
        end else if (stack_level < nbytes) begin
            res.status = ST_UNDERFLOW;
        end else begin
            stack_level -= nbytes;
            for (int k = 0; k < nbytes; k++)
                res.value[8*k +: 8] = stack_bytes[stack_level + k];
        end
        res.fill = FILL_W'(stack_level);
        return res;
    endfunction

    always @(posedge aclk) begin
        stack_result_t want;
        if (!aresetn) begin
            stack_level = 0;
            expected_results.delete();
        end else begin
            // results first: a request taken at this edge cannot answer at it
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result value %h status %0d fill %0d",
                             $time, m_pop_value, m_status, m_fill_level);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_pop_value !== want.value) begin
                        $display("%0t: pop_value expected %h actual %h",
                                 $time, want.value, m_pop_value);
                        errors++;
                    end
                    if (m_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_status);
                        errors++;
                    end
                    if (m_fill_level !== want.fill) begin
                        $display("%0t: fill_level expected %0d actual %0d",
                                 $time, want.fill, m_fill_level);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(predict_request(s_func, s_size_code,
                                                           s_push_value));
        end
        fail_count  <= errors;
        outstanding <= expected_results.size();
    end

endmodule

/* bench/mixed_width_byte_stack_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mixed_width_byte_stack_top_test
// Drives push and pop requests of every width into the byte stack: a short
// directed sequence, then random traffic in three idling phases, including
// a run to full with overflow attempts. A checker alongside predicts and
// compares every result.
// ----------------------------------------------------------------------------
module mixed_width_byte_stack_top_test;
    import bstk_pkg::*;

    localparam int STACK_BYTES = DEPTH_BYTES_DEF;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_func;
    logic [1:0]        s_size_code;
    logic [63:0]       s_push_value;
    logic              m_valid;
    logic              m_ready;
    logic [63:0]       m_pop_value;
    logic [1:0]        m_status;
    logic [FILL_W-1:0] m_fill_level;

    int fail_count;
    int outstanding;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int burst_left    = 0;
    int depth_now     = 0;   // fill level as the sender sees it, for shaping only

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    mixed_width_byte_stack_top #(.DEPTH_BYTES(STACK_BYTES)) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_size_code  (s_size_code),
        .s_push_value (s_push_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pop_value  (m_pop_value),
        .m_status     (m_status),
        .m_fill_level (m_fill_level)
    );

    byte_stack_checker #(.DEPTH_BYTES(STACK_BYTES)) stack_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_size_code  (s_size_code),
        .s_push_value (s_push_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pop_value  (m_pop_value),
        .m_status     (m_status),
        .m_fill_level (m_fill_level),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [63:0] random_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_request(input logic func, input logic [1:0] size_code,
                                input logic [63:0] value);
        int nbytes;
        nbytes = 32'(1) << size_code;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            while ($urandom_range(99) < send_idle_pct) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid      <= 1'b1;
        s_func       <= func;
        s_size_code  <= size_code;
        s_push_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (func == FUNC_PUSH) begin
            if (depth_now + nbytes <= STACK_BYTES) depth_now += nbytes;
        end else if (depth_now >= nbytes) begin
            depth_now -= nbytes;
        end
    endtask

    // hold off until the checker has nothing outstanding
    task automatic wait_all_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // blocks of push-heavy, pop-heavy or balanced traffic
    task automatic random_phase(input int count);
        int mode;
        int push_pct;
        mode = 0;
        for (int i = 0; i < count; i++) begin
            if (i % 20 == 0) mode = $urandom_range(2);
            if (i % 48 == 0) burst_left = 12;
            push_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
            send_request(($urandom_range(99) < push_pct) ? FUNC_PUSH : FUNC_POP,
                         2'($urandom_range(3)), random_word());
        end
    endtask

    // fill to the last byte, then try every width against a full stack
    task automatic fill_to_top();
        logic [1:0] size_code;
        while (depth_now < STACK_BYTES) begin
            if (STACK_BYTES - depth_now >= 8)      size_code = 2'd3;
            else if (STACK_BYTES - depth_now >= 4) size_code = 2'd2;
            else if (STACK_BYTES - depth_now >= 2) size_code = 2'd1;
            else                                   size_code = 2'd0;
            send_request(FUNC_PUSH, size_code, random_word());
        end
        for (int code = 0; code < 4; code++)
            send_request(FUNC_PUSH, 2'(code), random_word());
        // four bytes free: eight refused, four fit, then one refused
        send_request(FUNC_POP,  2'd2, random_word());
        send_request(FUNC_PUSH, 2'd3, random_word());
        send_request(FUNC_PUSH, 2'd2, random_word());
        send_request(FUNC_PUSH, 2'd0, random_word());
    endtask

    initial begin
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_func       <= FUNC_PUSH;
        s_size_code  <= 2'd0;
        s_push_value <= '0;
        send_idle_pct = 19;
        recv_idle_pct = 46;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // pops on an empty stack, every width
        for (int code = 0; code < 4; code++)
            send_request(FUNC_POP, 2'(code), random_word());
        send_request(FUNC_PUSH, 2'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(FUNC_PUSH, 2'd1, 64'h0000_0000_0000_8001);
        send_request(FUNC_PUSH, 2'd2, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(FUNC_PUSH, 2'd3, 64'h8000_0000_0000_0001);
        send_request(FUNC_PUSH, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(FUNC_PUSH, 2'd3, 64'h0000_0000_0000_0000);
        // pops that straddle earlier pushes of other widths
        send_request(FUNC_POP, 2'd3, random_word());
        send_request(FUNC_POP, 2'd2, random_word());
        send_request(FUNC_POP, 2'd2, random_word());
        send_request(FUNC_POP, 2'd3, random_word());
        send_request(FUNC_POP, 2'd1, random_word());
        send_request(FUNC_POP, 2'd2, random_word());
        // one byte held: wider pops refused
        send_request(FUNC_POP, 2'd1, random_word());
        send_request(FUNC_POP, 2'd3, random_word());
        send_request(FUNC_POP, 2'd0, random_word());
        send_request(FUNC_PUSH, 2'd0, 64'h0);
        send_request(FUNC_PUSH, 2'd0, 64'h5A5A_5A5A_5A5A_5AA5);
        send_request(FUNC_POP,  2'd1, random_word());

        random_phase(110);

        send_idle_pct = 46;
        recv_idle_pct = 19;
        fill_to_top();
        wait_all_results();
        random_phase(80);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(110);

        wait_all_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/bstk_pkg.sv
rtl/bstk_lane_ram.sv
rtl/mixed_width_byte_stack_top.sv
bench/byte_stack_checker.sv
bench/mixed_width_byte_stack_top_test.sv
